/* hdl/vca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vca_pkg;

    // Default size of the dynamic channel table.
    localparam int DYNAMIC_CHANNELS_DEF = 128;

    // Request operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // A sub-channel of all ones (-1) matches any slot on start.
    localparam logic [3:0] SLOT_ANY  = 4'hF;
    localparam logic [3:0] SLOT_NONE = 4'h0;

    // Initial best remaining life of a scan.
    localparam logic [31:0] LIFE_MAX = 32'h7fff_ffff;

    localparam logic [15:0] CFG_PLAYER_ENTITY = 16'd0;

    typedef struct packed {
        logic [1:0]        operation;
        logic [15:0]       entity;
        logic signed [3:0] sub_channel;
        logic [30:0]       now;
        logic [23:0]       sound_length;
        logic              audible;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [6:0] channel_index;
        logic       stole_active;
        logic       started;
    } rsp_t;

    // One channel table entry as held by a cell.
    typedef struct packed {
        logic [15:0] owner_entity;
        logic [3:0]  owner_slot;
        logic [31:0] end_time;
        logic        active;
    } entry_t;

    // Control broadcast to every cell of the ring.
    typedef struct packed {
        logic shift;
        logic clear;
        logic write;
        logic keep_owner;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* hdl/vca_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module vca_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  vca_pkg::cell_ctrl_t  ctrl,
    input  wire                  sel,
    input  vca_pkg::entry_t      wr_data,
    input  vca_pkg::entry_t      neighbor,
    output vca_pkg::entry_t      entry
);
    import vca_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            entry_next = '0;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor;
        end
        else if (ctrl.write && sel)
        begin
            entry_next = wr_data;
            // A stop keeps the owner and slot of the entry.
            if (ctrl.keep_owner)
            begin
                entry_next.owner_entity = entry_reg.owner_entity;
                entry_next.owner_slot   = entry_reg.owner_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* hdl/vca_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module vca_scan #(
    parameter int IDX_W = 7
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    init,
    input  wire                    step,
    input  wire  [1:0]             operation,
    input  wire  [15:0]            entity,
    input  wire  [3:0]             slot,
    input  wire  [30:0]            now,
    input  wire  [15:0]            player,
    input  vca_pkg::entry_t        head,
    input  wire  [IDX_W-1:0]       index,
    output logic                   found,
    output logic [IDX_W-1:0]       pick,
    output logic                   stole
);
    import vca_pkg::*;

    logic             done_reg,  done_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pick_reg,  pick_next;
    logic             stole_reg, stole_next;
    logic [31:0]      best_reg,  best_next;

    logic        hit_start;
    logic        hit_stop;
    logic        protect;
    logic [31:0] life;
    logic        shorter;

    always_comb
    begin
        hit_start = (slot != SLOT_NONE) && (head.owner_entity == entity) &&
                    ((head.owner_slot == slot) || (slot == SLOT_ANY));
        hit_stop  = (head.owner_entity == entity) && (head.owner_slot == slot);
        protect   = (head.owner_entity == player) && (entity != player) && head.active;
        life      = head.end_time - {1'b0, now};
        shorter   = $signed(life) < $signed(best_reg);
    end

    always_comb
    begin
        done_next  = done_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        stole_next = stole_reg;
        best_next  = best_reg;
        if (init)
        begin
            done_next  = 1'b0;
            found_next = 1'b0;
            best_next  = LIFE_MAX;
        end
        else if (step && !done_reg)
        begin
            if (operation == OP_STOP)
            begin
                if (hit_stop)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pick_next  = index;
                end
            end
            else if (hit_start)
            begin
                // The owner's own matching slot wins outright.
                done_next  = 1'b1;
                found_next = 1'b1;
                pick_next  = index;
                stole_next = head.active;
            end
            else if (!protect && shorter)
            begin
                found_next = 1'b1;
                pick_next  = index;
                stole_next = head.active;
                best_next  = life;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg  <= pick_next;
        stole_reg <= stole_next;
        best_reg  <= best_next;
    end

    assign found = found_reg;
    assign pick  = pick_reg;
    assign stole = stole_reg;

endmodule

`default_nettype wire

/* hdl/voice_channel_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// A start or stop request is accepted in idle, scans the whole ring, passes the write state and
// then waits in the result state until the previous result is taken; clear-all and unknown
// operations go straight from idle to the result state. No new request is taken before the
// result is loaded; a start or stop is held by the full rotation of the cell ring past the scanner.
// Reset (rst_n, asynchronous, active low) zeroes every table entry and player_entity at once.
module voice_channel_allocator #(
    parameter int DYNAMIC_CHANNELS = vca_pkg::DYNAMIC_CHANNELS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,

    input  wire                req_valid,
    output logic               req_ready,
    input  vca_pkg::req_t      req,

    output logic               rsp_valid,
    input  wire                rsp_ready,
    output vca_pkg::rsp_t      rsp,

    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [1:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vca_pkg::*;

    localparam int IDX_W = (DYNAMIC_CHANNELS > 1) ? $clog2(DYNAMIC_CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > 7) ? IDX_W : 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DYNAMIC_CHANNELS - 1);
    localparam logic [1:0] ADDR_PLAYER = 2'd0;

    // The channel table lives in a ring of cells. During a scan the ring rotates one place
    // per cycle toward cell 0, so cell 0 presents entry k at scan step k. After a full turn
    // every entry is back in its home cell, and the chosen entry is rewritten in place.

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg,   cnt_next;
    req_t             req_reg;
    rsp_t             rsp_reg,   rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [15:0]      player_reg;

    // Controls decoded from the state.
    logic        accept;
    logic        scan_init;
    logic        scan_step;
    logic        load_rsp;
    cell_ctrl_t  ctrl;

    entry_t      cells [DYNAMIC_CHANNELS];
    entry_t      wr_data;
    logic [DYNAMIC_CHANNELS-1:0] active_vec;

    logic             scan_found;
    logic [IDX_W-1:0] scan_pick;
    logic             scan_stole;
    logic [EXT_W-1:0] pick_ext;

    // ---------------------------------------------------------------------
    // Configuration port. There is a single register, so every write lands on it;
    // a read returns it at its own address and zero elsewhere.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_reg <= CFG_PLAYER_ENTITY;
        end
        else if (psel && penable && pwrite && pready)
        begin
            player_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PLAYER) ? {16'd0, player_reg} : 32'd0;

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.operation) inside
                        OP_START, OP_STOP: state_next = ST_SCAN;
                        default:           state_next = ST_RESULT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs.
    // ---------------------------------------------------------------------
    always_comb
    begin
        req_ready       = 1'b0;
        accept          = 1'b0;
        scan_init       = 1'b0;
        scan_step       = 1'b0;
        load_rsp        = 1'b0;
        ctrl            = '0;
        ctrl.keep_owner = (req_reg.operation == OP_STOP);
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                accept    = req_valid;
                scan_init = req_valid;
                // Clear-all wipes the ring at the edge that accepts the request.
                ctrl.clear = req_valid && (req.operation == OP_CLEAR);
            end
            ST_SCAN:
            begin
                scan_step  = 1'b1;
                ctrl.shift = 1'b1;
            end
            ST_WRITE:
            begin
                ctrl.write = scan_found &&
                             ((req_reg.operation == OP_START) ||
                              (req_reg.operation == OP_STOP));
            end
            ST_RESULT:
            begin
                load_rsp = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = '0;
        end
        else if (scan_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Write data and result.
    // ---------------------------------------------------------------------
    always_comb
    begin
        wr_data.owner_entity = req_reg.entity;
        wr_data.owner_slot   = req_reg.sub_channel;
        wr_data.active       = req_reg.audible && (req_reg.operation == OP_START);
        if (wr_data.active)
        begin
            wr_data.end_time = {1'b0, req_reg.now} + {8'd0, req_reg.sound_length};
        end
        else
        begin
            wr_data.end_time = '0;
        end
    end

    assign pick_ext = EXT_W'(scan_pick);

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.operation == OP_START && scan_found)
        begin
            rsp_next.found         = 1'b1;
            rsp_next.channel_index = pick_ext[6:0];
            rsp_next.stole_active  = scan_stole;
            rsp_next.started       = req_reg.audible;
        end
        else if (req_reg.operation == OP_STOP && scan_found)
        begin
            rsp_next.found         = 1'b1;
            rsp_next.channel_index = pick_ext[6:0];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------------
    // Cell ring. Each cell takes its upper neighbor's entry on a shift; the last cell
    // wraps around and takes the entry of cell 0.
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < DYNAMIC_CHANNELS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % DYNAMIC_CHANNELS;

        vca_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sel      (scan_pick == IDX_W'(i)),
            .wr_data  (wr_data),
            .neighbor (cells[NXT]),
            .entry    (cells[i])
        );

        assign active_vec[i] = cells[i].active;
    end

    // ---------------------------------------------------------------------
    // Scanner at the head of the ring.
    // ---------------------------------------------------------------------
    vca_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (scan_init),
        .step      (scan_step),
        .operation (req_reg.operation),
        .entity    (req_reg.entity),
        .slot      (req_reg.sub_channel),
        .now       (req_reg.now),
        .player    (player_reg),
        .head      (cells[0]),
        .index     (cnt_reg),
        .found     (scan_found),
        .pick      (scan_pick),
        .stole     (scan_stole)
    );

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // A scan ends after exactly one full turn of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (cnt_reg == LAST_IDX) |=> (state_reg == ST_WRITE))
        else $error("scan did not end after a full turn of the ring");

    // A clear-all request leaves no channel active.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.operation == OP_CLEAR) |=> (active_vec == '0))
        else $error("channel still active after clear-all");

    // Stealing or starting is only reported for a chosen channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.stole_active || rsp.started) |-> rsp.found)
        else $error("steal or start reported without a chosen channel");

    // The ring only moves while a scan is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |-> (state_reg == ST_SCAN) && !ctrl.write && !ctrl.clear)
        else $error("ring moved outside a scan");

endmodule

`default_nettype wire
